FILE: rtl/core/kernel_cache_fifo_lookup_core_defines.svh
// Assertion macros for the kernel cache lookup core.
`ifndef KERNEL_CACHE_FIFO_LOOKUP_CORE_DEFINES_SVH
`define KERNEL_CACHE_FIFO_LOOKUP_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled in reset.
`define KCL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kcl same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define KCL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kcl next-cycle check failed");

`else

`define KCL_ASSERT_NOW(label, ante, cons)

`define KCL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/core/kcl_pkg.sv
// Types, constants and helper functions for the kernel cache lookup core.
`timescale 1ns / 1ps
`default_nettype none
package kcl_pkg;

    localparam int CAPACITY        = 16;
    localparam int BYTES_PER_ENTRY = 4096;
    localparam int IDX_W           = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W           = 5;
    localparam int LIM_W           = 5;
    localparam int BYTES_W         = 17;
    localparam int Q_DEPTH         = 2;
    localparam int Q_AW            = 1;

    localparam logic [63:0] HASH_BASIS     = 64'hCBF2_9CE4_8422_2325;
    // FNV-64 prime is 2^40 + 435
    localparam int          HASH_PRIME_SH  = 40;
    localparam logic [63:0] HASH_PRIME_LO  = 64'd435;
    localparam logic [31:0] MAX32          = 32'hFFFF_FFFF;
    localparam logic [BYTES_W-1:0] MAX_BYTES = {BYTES_W{1'b1}};

    typedef enum logic
    {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } kcl_op_t;

    typedef enum logic
    {
        BK_IDLE  = 1'b0,
        BK_APPLY = 1'b1
    } kcl_bk_state_t;

    typedef struct packed
    {
        kcl_op_t     op;
        logic [63:0] tag;
        logic [31:0] kref;
    } kcl_cmd_t;

    typedef struct packed
    {
        logic               hit;
        logic [31:0]        found_ref;
        logic               evicted;
        logic [CNT_W-1:0]   entry_count;
        logic [31:0]        hit_total;
        logic [31:0]        miss_total;
        logic [31:0]        inserted_total;
        logic [BYTES_W-1:0] code_bytes;
    } kcl_result_t;

    function automatic logic [63:0] kcl_fold(input logic [63:0] h, input logic [31:0] pid);
        logic [63:0] x;
        x = h ^ {32'd0, pid};
        return (x << HASH_PRIME_SH) + (x * HASH_PRIME_LO);
    endfunction

    function automatic logic [31:0] kcl_sat_inc(input logic [31:0] v);
        return (v == MAX32) ? v : v + 32'd1;
    endfunction

    function automatic logic [BYTES_W-1:0] kcl_bytes_for(input logic [CNT_W-1:0] c);
        logic [31:0] b;
        b = 32'(c) * 32'(BYTES_PER_ENTRY);
        return (b > 32'(MAX_BYTES)) ? MAX_BYTES : b[BYTES_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/kcl_in_if.sv
// Request channel: one pattern id word per transfer.
`timescale 1ns / 1ps
`default_nettype none
interface kcl_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] pattern_id;
    logic        last;
    logic [31:0] kernel_ref;

    modport source (output valid, op, pattern_id, last, kernel_ref, input ready);
    modport sink   (input valid, op, pattern_id, last, kernel_ref, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/kcl_out_if.sv
// Response channel: one result word per completed shape.
`timescale 1ns / 1ps
`default_nettype none
interface kcl_out_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] found_ref;
    logic        evicted;
    logic [4:0]  entry_count;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] inserted_total;
    logic [16:0] code_bytes;

    modport source (output valid, hit, found_ref, evicted, entry_count, hit_total,
                    miss_total, inserted_total, code_bytes, input ready);
    modport sink   (input valid, hit, found_ref, evicted, entry_count, hit_total,
                    miss_total, inserted_total, code_bytes, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/kcl_front.sv
// Front end: folds pattern ids into the shape hash and queues finished commands.
`timescale 1ns / 1ps
`default_nettype none
module kcl_front
    import kcl_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    kcl_in_if.sink        req,
    output kcl_cmd_t      push_data,
    output logic          push_valid,
    input  wire logic     push_ready
);

    logic [63:0] hash_reg;
    logic [63:0] hash_next;
    logic [63:0] folded;
    logic        accept;

    assign folded     = kcl_fold(hash_reg, req.pattern_id);
    // stall every word while the queue is full, keeps ready independent of last
    assign req.ready  = push_ready;
    assign accept     = req.valid && push_ready;
    assign push_valid = req.valid && req.last;

    always_comb
    begin
        push_data.op   = kcl_op_t'(req.op);
        push_data.tag  = folded;
        push_data.kref = req.kernel_ref;
        hash_next      = hash_reg;
        if (accept)
        begin
            hash_next = req.last ? HASH_BASIS : folded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= HASH_BASIS;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/kcl_cmd_fifo.sv
// Short command queue between the hash front end and the cache back end.
`timescale 1ns / 1ps
`default_nettype none
module kcl_cmd_fifo
    import kcl_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire kcl_cmd_t  push_data,
    input  wire logic      push_valid,
    output logic           push_ready,
    output kcl_cmd_t       pop_data,
    output logic           pop_valid,
    input  wire logic      pop_ready,
    output logic [Q_AW:0]  level
);

    kcl_cmd_t          mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_next;
    logic [Q_AW:0]     level_reg;
    logic [Q_AW:0]     level_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (level_reg != (Q_AW+1)'(Q_DEPTH));
    assign pop_valid  = (level_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign level      = level_reg;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/kcl_back.sv
// Back end: tag compare, FIFO-ordered entry table, counters and result register.
`timescale 1ns / 1ps
`default_nettype none
module kcl_back
    import kcl_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [LIM_W-1:0] cache_limit,
    input  wire kcl_cmd_t         pop_data,
    input  wire logic             pop_valid,
    output logic                  pop_ready,
    kcl_out_if.source             rsp
);

    logic [63:0]       tag_reg   [CAPACITY];
    logic [63:0]       tag_next  [CAPACITY];
    logic [31:0]       ref_reg   [CAPACITY];
    logic [31:0]       ref_next  [CAPACITY];
    logic [31:0]       hits_reg  [CAPACITY];
    logic [31:0]       hits_next [CAPACITY];

    kcl_bk_state_t     state_reg;
    kcl_bk_state_t     state_next;
    kcl_cmd_t          cmd_reg;
    kcl_cmd_t          cmd_next;
    logic [CAPACITY-1:0] match_reg;
    logic [CAPACITY-1:0] match_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [31:0]       hit_tot_reg;
    logic [31:0]       hit_tot_next;
    logic [31:0]       miss_tot_reg;
    logic [31:0]       miss_tot_next;
    logic [31:0]       ins_tot_reg;
    logic [31:0]       ins_tot_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    kcl_result_t       out_reg;
    kcl_result_t       out_next;

    logic              fire;
    logic              any_hit;
    logic [IDX_W-1:0]  first_idx;
    logic [CNT_W-1:0]  eff_lim;
    logic              full;
    logic [CNT_W-1:0]  cnt_mid;
    logic              room;

    assign rsp.valid          = out_valid_reg;
    assign rsp.hit            = out_reg.hit;
    assign rsp.found_ref      = out_reg.found_ref;
    assign rsp.evicted        = out_reg.evicted;
    assign rsp.entry_count    = out_reg.entry_count;
    assign rsp.hit_total      = out_reg.hit_total;
    assign rsp.miss_total     = out_reg.miss_total;
    assign rsp.inserted_total = out_reg.inserted_total;
    assign rsp.code_bytes     = out_reg.code_bytes;

    assign pop_ready = (state_reg == BK_IDLE);

    // oldest matching entry wins
    always_comb
    begin
        first_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                first_idx = IDX_W'(i);
            end
        end
    end
    assign any_hit = |match_reg;

    always_comb
    begin
        if (cache_limit == '0)
        begin
            eff_lim = CNT_W'(1);
        end
        else if (cache_limit > LIM_W'(CAPACITY))
        begin
            eff_lim = CNT_W'(CAPACITY);
        end
        else
        begin
            eff_lim = CNT_W'(cache_limit);
        end
    end

    assign full    = (count_reg >= eff_lim) && (count_reg != '0);
    assign cnt_mid = full ? count_reg - 1'b1 : count_reg;
    assign room    = (cnt_mid < CNT_W'(CAPACITY));

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        match_next     = match_reg;
        count_next     = count_reg;
        hit_tot_next   = hit_tot_reg;
        miss_tot_next  = miss_tot_reg;
        ins_tot_next   = ins_tot_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        fire           = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tag_next[i]  = tag_reg[i];
            ref_next[i]  = ref_reg[i];
            hits_next[i] = hits_reg[i];
        end

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            BK_IDLE:
            begin
                if (pop_valid)
                begin
                    cmd_next = pop_data;
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        match_next[i] = (CNT_W'(i) < count_reg)
                                        && (tag_reg[i] == pop_data.tag);
                    end
                    state_next = BK_APPLY;
                end
            end
            BK_APPLY:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    fire       = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (fire)
        begin
            out_next.hit       = 1'b0;
            out_next.found_ref = '0;
            out_next.evicted   = 1'b0;
            if (cmd_reg.op == OP_LOOKUP)
            begin
                if (any_hit)
                begin
                    out_next.hit          = 1'b1;
                    out_next.found_ref    = ref_reg[first_idx];
                    hits_next[first_idx]  = kcl_sat_inc(hits_reg[first_idx]);
                    hit_tot_next          = kcl_sat_inc(hit_tot_reg);
                end
                else
                begin
                    miss_tot_next = kcl_sat_inc(miss_tot_reg);
                end
            end
            else
            begin
                out_next.evicted = full;
                // shift out the oldest, then append at the first free slot
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (full && (i < CAPACITY - 1))
                    begin
                        tag_next[i]  = tag_reg[i + 1];
                        ref_next[i]  = ref_reg[i + 1];
                        hits_next[i] = hits_reg[i + 1];
                    end
                    if (room && (CNT_W'(i) == cnt_mid))
                    begin
                        tag_next[i]  = cmd_reg.tag;
                        ref_next[i]  = cmd_reg.kref;
                        hits_next[i] = '0;
                    end
                end
                count_next   = room ? cnt_mid + 1'b1 : cnt_mid;
                ins_tot_next = kcl_sat_inc(ins_tot_reg);
            end
            out_next.entry_count    = count_next;
            out_next.hit_total      = hit_tot_next;
            out_next.miss_total     = miss_tot_next;
            out_next.inserted_total = ins_tot_next;
            out_next.code_bytes     = kcl_bytes_for(count_next);
            out_valid_next          = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        match_reg <= match_next;
        out_reg   <= out_next;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tag_reg[i]  <= tag_next[i];
            ref_reg[i]  <= ref_next[i];
            hits_reg[i] <= hits_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            hit_tot_reg   <= '0;
            miss_tot_reg  <= '0;
            ins_tot_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            hit_tot_reg   <= hit_tot_next;
            miss_tot_reg  <= miss_tot_next;
            ins_tot_reg   <= ins_tot_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/kernel_cache_fifo_lookup_core.sv
// Top level of the kernel cache lookup core.
//
// Usage: a shape enters on req as a run of pattern id words, last set on
// the final one; op and kernel_ref are taken from that final word. Each
// id is folded into a 64-bit FNV-1a hash, one id per cycle while the queue
// has room. The finished command goes into a two-deep queue; the back end
// takes it, compares the tag against all held entries at once into a match
// register, then applies the lookup or the insert (oldest-first eviction),
// loading one result word on rsp, and only then takes the next command.
// cfg_we writes cache_limit (reset 16); write it only while idle.
// Reset sets the hash to its basis and clears the entry count and all
// totals; rsp.valid stays low. If rsp is stalled the result is held, the
// back end stops after its compare step, the queue fills and then
// req.ready drops.
`timescale 1ns / 1ps
`default_nettype none
`include "kernel_cache_fifo_lookup_core_defines.svh"
module kernel_cache_fifo_lookup_core
    import kcl_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [LIM_W-1:0] cfg_wdata,
    kcl_in_if.sink                req,
    kcl_out_if.source             rsp
);

    logic [LIM_W-1:0] limit_reg;
    kcl_cmd_t         push_data;
    logic             push_valid;
    logic             push_ready;
    kcl_cmd_t         pop_data;
    logic             pop_valid;
    logic             pop_ready;
    logic [Q_AW:0]    q_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIM_W'(CAPACITY);
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    kcl_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    kcl_cmd_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .level      (q_level)
    );

    kcl_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cache_limit (limit_reg),
        .pop_data    (pop_data),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .rsp         (rsp)
    );

    `KCL_ASSERT_NOW(a_evict_shape, rsp.valid && rsp.evicted, (rsp.entry_count != 0) && !rsp.hit)
    `KCL_ASSERT_NOW(a_bytes_match, rsp.valid, rsp.code_bytes == kcl_bytes_for(rsp.entry_count))
    `KCL_ASSERT_NOW(a_count_bound, rsp.valid, rsp.entry_count <= CNT_W'(CAPACITY))
    `KCL_ASSERT_NEXT(a_full_stalls, q_level == (Q_AW+1)'(Q_DEPTH) && !pop_ready, q_level != 0)

endmodule
`default_nettype wire
